// ===== design/memory_test_pattern_gen_check_core_defines.svh =====
// Assertion macros for the memory test pattern core.
// Depends on nothing; included by the core top level, which carries the assertions.
`ifndef MEMORY_TEST_PATTERN_GEN_CHECK_CORE_DEFINES_SVH
`define MEMORY_TEST_PATTERN_GEN_CHECK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle.
`define MTPG_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Antecedent true implies consequent in the next cycle.
`define MTPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define MTPG_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MTPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/mtpg_pkg.sv =====
// Shared types, constants and the pattern class table of the memory test core.
// Depends on nothing.
`default_nettype none

package mtpg_pkg;

   localparam int unsigned WORD_BITS   = 16;
   localparam int unsigned BLOCK_WORDS = 32;
   localparam int unsigned WALK_SPAN   = 16;
   localparam int unsigned INDEX_BITS  = $clog2(BLOCK_WORDS);
   localparam int unsigned WALK_BITS   = $clog2(WALK_SPAN);
   localparam int unsigned DONE_BITS   = 31;
   localparam int unsigned LEN_BITS    = 32;

   localparam logic [LEN_BITS-1:0] LEN_RESET = 32'd8388608;

   localparam logic [WORD_BITS-1:0] PAT_ONES  = 16'hFFFF;
   localparam logic [WORD_BITS-1:0] PAT_ZEROS = 16'h0000;
   localparam logic [WORD_BITS-1:0] PAT_AA    = 16'hAAAA;
   localparam logic [WORD_BITS-1:0] PAT_55    = 16'h5555;

   typedef enum logic [2:0] {
      KIND_ONES  = 3'd0,
      KIND_ZEROS = 3'd1,
      KIND_AA    = 3'd2,
      KIND_55    = 3'd3,
      KIND_WALK1 = 3'd4,
      KIND_WALK0 = 3'd5
   } kind_type;

   localparam kind_type KIND_TABLE [BLOCK_WORDS] = '{
      KIND_ONES,  KIND_ZEROS, KIND_WALK1, KIND_WALK0,
      KIND_WALK1, KIND_WALK0, KIND_ZEROS, KIND_55,
      KIND_ZEROS, KIND_ONES,  KIND_WALK1, KIND_WALK0,
      KIND_WALK1, KIND_WALK0, KIND_ONES,  KIND_55,
      KIND_AA,    KIND_ZEROS, KIND_WALK0, KIND_WALK1,
      KIND_WALK0, KIND_WALK1, KIND_ZEROS, KIND_AA,
      KIND_55,    KIND_ONES,  KIND_WALK0, KIND_WALK1,
      KIND_WALK0, KIND_WALK1, KIND_ONES,  KIND_AA
   };

   // Position of the current word within its pass.
   typedef struct packed {
      logic [INDEX_BITS-1:0] word_index;
      logic [WALK_BITS-1:0]  walk_bit;
      logic [DONE_BITS-1:0]  words_done;
      logic                  last;
   } pos_type;

   // One result word.
   typedef struct packed {
      logic [WORD_BITS-1:0] expected;
      logic [LEN_BITS-1:0]  byte_offset;
      logic                 mismatch;
      kind_type             kind;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/memory_test_pattern_gen_check_core.sv =====
// Top level of the memory test pattern generator and checker.
// Depends on mtpg_pkg, mtpg_position, mtpg_pattern and the defines header.
//
//   channel  direction  handshake           word contents
//   req_     in         req_valid/stall     mode, read_word, restart
//   rsp_     out        rsp_valid/stall     expected_word, byte_offset,
//                                           mismatch, error_kind, pass_last
//   csr_     in         csr_valid/ready     test_length_bytes (wdata)
//
// One word per cycle sustained while rsp_stall stays low. A result is registered
// after the position and pattern logic, in the result register, or in the skid
// register while the result register is held. The two-entry output
// keeps req_stall registered: it rises only when both entries are full.
// Synchronous reset clears the position counters, both valid flags and
// loads test_length_bytes with 8388608. No clearing pass is needed.
`default_nettype none

`include "memory_test_pattern_gen_check_core_defines.svh"

module memory_test_pattern_gen_check_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request words
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_mode,
   input  wire logic [mtpg_pkg::WORD_BITS-1:0] req_read_word,
   input  wire logic                           req_restart,
   // result words
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [mtpg_pkg::WORD_BITS-1:0]      rsp_expected_word,
   output logic [mtpg_pkg::LEN_BITS-1:0]       rsp_byte_offset,
   output logic                                rsp_mismatch,
   output logic [2:0]                          rsp_error_kind,
   output logic                                rsp_pass_last,
   // configuration write
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mtpg_pkg::LEN_BITS-1:0]  csr_wdata
);
   import mtpg_pkg::*;

   // configuration
   logic [LEN_BITS-1:0] len_ff;
   logic [LEN_BITS-1:0] pass_words;

   // handshake
   logic accept;
   logic out_take;

   // two-entry output
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   // datapath
   pos_type              pos;
   kind_type             kind;
   logic [WORD_BITS-1:0] expected;
   rsp_type              fresh;

   // Writes must only be issued while idle; the block does not enforce it and always takes them.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         len_ff <= csr_wdata;
      end
   end

   // Drop the trailing odd byte; a pass is at least one word.
   always_comb begin
      pass_words = {1'b0, len_ff[LEN_BITS-1:1]};
      if (pass_words == '0) begin
         pass_words = LEN_BITS'(1);
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   // Advance the position on every accepted word.
   mtpg_position u_position (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .restart    (req_restart),
      .pass_words (pass_words),
      .pos        (pos)
   );

   mtpg_pattern u_pattern (
      .word_index (pos.word_index),
      .walk_bit   (pos.walk_bit),
      .kind       (kind),
      .expected   (expected)
   );

   // Build the result word; mismatch only counts in check mode.
   always_comb begin
      fresh.expected    = expected;
      fresh.byte_offset = {pos.words_done, 1'b0};
      fresh.mismatch    = req_mode && (req_read_word != expected);
      fresh.kind        = kind;
      fresh.last        = pos.last;
   end

   // Keep order: the skid entry always moves out before a fresh word.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = fresh;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         // result register is held: park the word in the skid entry
         skid_in       = fresh;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_expected_word = out_ff.expected;
   assign rsp_byte_offset   = out_ff.byte_offset;
   assign rsp_mismatch      = out_ff.mismatch;
   assign rsp_error_kind    = out_ff.kind;
   assign rsp_pass_last     = out_ff.last;

   // Skid entry is only filled behind a held result.
   `MTPG_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // Offsets are whole words.
   `MTPG_ASSERT_IMPLIES(a_offset_even, clock, reset, rsp_valid, !rsp_byte_offset[0])
   // The zeros class always yields a zero word.
   `MTPG_ASSERT_IMPLIES(a_zeros_word, clock, reset,
      rsp_valid && (out_ff.kind == KIND_ZEROS), rsp_expected_word == PAT_ZEROS)
   // Accepting a last word wraps the position to the start of a pass.
   `MTPG_ASSERT_NEXT(a_wrap_on_last, clock, reset, accept && pos.last,
      !req_restart || (pos.words_done == '0))

endmodule

`default_nettype wire

// ===== design/mtpg_position.sv =====
// Pass position tracker: word index in block, walking bit and words done.
// Depends on mtpg_pkg.
`default_nettype none

module mtpg_position (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          restart,
   input  wire logic [mtpg_pkg::LEN_BITS-1:0] pass_words,
   output mtpg_pkg::pos_type                  pos
);
   import mtpg_pkg::*;

   logic [INDEX_BITS-1:0] word_index_ff, word_index_in;
   logic [WALK_BITS-1:0]  walk_bit_ff,   walk_bit_in;
   logic [DONE_BITS-1:0]  words_done_ff, words_done_in;

   logic [INDEX_BITS-1:0] cur_index;
   logic [WALK_BITS-1:0]  cur_walk;
   logic [DONE_BITS-1:0]  cur_done;
   logic [LEN_BITS-1:0]   done_plus;
   logic                  last;

   always_comb begin
      // clear the counters ahead of the word on restart
      cur_index = restart ? '0 : word_index_ff;
      cur_walk  = restart ? '0 : walk_bit_ff;
      cur_done  = restart ? '0 : words_done_ff;
      done_plus = {1'b0, cur_done} + LEN_BITS'(1);
      last      = (done_plus >= pass_words);

      word_index_in = word_index_ff;
      walk_bit_in   = walk_bit_ff;
      words_done_in = words_done_ff;
      if (advance) begin
         if (last) begin
            word_index_in = '0;
            walk_bit_in   = '0;
            words_done_in = '0;
         end else begin
            word_index_in = cur_index + INDEX_BITS'(1);
            walk_bit_in   = (cur_index == INDEX_BITS'(BLOCK_WORDS - 1)) ?
                            cur_walk + WALK_BITS'(1) : cur_walk;
            words_done_in = done_plus[DONE_BITS-1:0];
         end
      end

      pos.word_index = cur_index;
      pos.walk_bit   = cur_walk;
      pos.words_done = cur_done;
      pos.last       = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff <= '0;
         walk_bit_ff   <= '0;
         words_done_ff <= '0;
      end else begin
         word_index_ff <= word_index_in;
         walk_bit_ff   <= walk_bit_in;
         words_done_ff <= words_done_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mtpg_pattern.sv =====
// Pattern lookup: class from the block table, then the pattern word.
// Depends on mtpg_pkg.
`default_nettype none

module mtpg_pattern (
   input  wire logic [mtpg_pkg::INDEX_BITS-1:0] word_index,
   input  wire logic [mtpg_pkg::WALK_BITS-1:0]  walk_bit,
   output mtpg_pkg::kind_type                   kind,
   output logic [mtpg_pkg::WORD_BITS-1:0]       expected
);
   import mtpg_pkg::*;

   logic [WORD_BITS-1:0] one_hot;

   always_comb begin
      kind    = KIND_TABLE[word_index];
      one_hot = WORD_BITS'(1) << walk_bit;
      case (kind)
         KIND_ONES:  expected = PAT_ONES;
         KIND_ZEROS: expected = PAT_ZEROS;
         KIND_AA:    expected = PAT_AA;
         KIND_55:    expected = PAT_55;
         KIND_WALK1: expected = one_hot;
         default:    expected = ~one_hot;
      endcase
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for memory_test_pattern_gen_check_core: walking-pattern words,
// check-mode compares, pass wrap and length register writes, under random idling.
// Depends on mtpg_pkg and the core RTL.
module tb_top;
   import mtpg_pkg::*;

   localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int ITEM_TARGET = 1150;
   localparam int LONG_HOLD   = 150;

   // Predicts one result word per request word from its own copy of the pass
   // position and the length register, and checks results in order.
   class pattern_scoreboard;
      logic [INDEX_BITS-1:0] word_index;
      logic [WALK_BITS-1:0]  walk_pos;
      logic [DONE_BITS-1:0]  words_done;
      logic [LEN_BITS-1:0]   length_bytes;
      rsp_type               expected_q[$];
      int                    errors;

      function new();
         clear_position();
         length_bytes = LEN_RESET;
         errors       = 0;
      endfunction

      function void clear_position();
         word_index = '0;
         walk_pos   = '0;
         words_done = '0;
      endfunction

      function void set_length(input logic [LEN_BITS-1:0] value);
         length_bytes = value;
      endfunction

      function logic [WORD_BITS-1:0] pattern_for(input kind_type kind,
                                                 input logic [WALK_BITS-1:0] bit_pos);
         logic [WORD_BITS-1:0] one;
         one = 16'd1 << bit_pos;
         case (kind)
            KIND_ONES:  return PAT_ONES;
            KIND_ZEROS: return PAT_ZEROS;
            KIND_AA:    return PAT_AA;
            KIND_55:    return PAT_55;
            KIND_WALK1: return one;
            default:    return ~one;
         endcase
      endfunction

      // Pattern the next word will be compared with, without advancing.
      function logic [WORD_BITS-1:0] peek_word(input logic restart);
         if (restart) return pattern_for(KIND_TABLE[0], '0);
         return pattern_for(KIND_TABLE[word_index], walk_pos);
      endfunction

      function void note_word(input logic mode, input logic [WORD_BITS-1:0] rd,
                              input logic restart);
         rsp_type             r;
         logic [LEN_BITS-1:0] pass_words;
         logic [LEN_BITS-1:0] next_done;
         if (restart) clear_position();
         pass_words = length_bytes >> 1;
         if (pass_words == 0) pass_words = 1;
         next_done     = {1'b0, words_done} + 32'd1;
         r.kind        = KIND_TABLE[word_index];
         r.expected    = pattern_for(r.kind, walk_pos);
         r.byte_offset = {words_done, 1'b0};
         r.mismatch    = mode && (rd != r.expected);
         r.last        = (next_done >= pass_words);
         expected_q.push_back(r);
         if (r.last) begin
            clear_position();
         end else begin
            words_done = next_done[DONE_BITS-1:0];
            word_index = word_index + 1'b1;
            if (word_index == 0) walk_pos = walk_pos + 1'b1;
         end
      endfunction

      task report(input string msg);
         errors++;
         $display("[%0t] error: %s", $realtime, msg);
      endtask

      task check_result(input logic [WORD_BITS-1:0] word, input logic [LEN_BITS-1:0] offset,
                        input logic mism, input logic [2:0] kind, input logic last);
         rsp_type r;
         if (expected_q.size() == 0) begin
            report("result word arrived with nothing outstanding");
            return;
         end
         r = expected_q.pop_front();
         if (word !== r.expected)
            report($sformatf("expected_word %h, want %h (offset %0d)",
                             word, r.expected, r.byte_offset));
         if (offset !== r.byte_offset)
            report($sformatf("byte_offset %0d, want %0d", offset, r.byte_offset));
         if (mism !== r.mismatch)
            report($sformatf("mismatch %b, want %b (offset %0d)", mism, r.mismatch,
                             r.byte_offset));
         if (kind !== r.kind)
            report($sformatf("error_kind %0d, want %0d (offset %0d)", kind, r.kind,
                             r.byte_offset));
         if (last !== r.last)
            report($sformatf("pass_last %b, want %b (offset %0d)", last, r.last,
                             r.byte_offset));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode = 1'b0;
   logic [WORD_BITS-1:0] req_read_word = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_BITS-1:0] rsp_expected_word;
   logic [LEN_BITS-1:0]  rsp_byte_offset;
   logic                 rsp_mismatch;
   logic [2:0]           rsp_error_kind;
   logic                 rsp_pass_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [LEN_BITS-1:0]  csr_wdata = LEN_RESET;

   pattern_scoreboard sb = new();
   int  items_sent   = 0;
   int  quiet_cycles = 0;
   int  hold_request = 0;   // receiver picks this up and holds stall that long
   bit  sender_gaps  = 1'b1;

   memory_test_pattern_gen_check_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_read_word     (req_read_word),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_expected_word (rsp_expected_word),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_mismatch      (rsp_mismatch),
      .rsp_error_kind    (rsp_error_kind),
      .rsp_pass_last     (rsp_pass_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Count cycles with no handshake on any channel; all samples are pre-edge values.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: check every accepted word, then stall for a random count.
   // Toggle between idling and back-to-back stretches now and then; take a long
   // hold-off when the stimulus asks for one.
   initial begin
      int hold_left;
      bit receiver_gaps;
      hold_left     = 0;
      receiver_gaps = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            sb.check_result(rsp_expected_word, rsp_byte_offset, rsp_mismatch,
                            rsp_error_kind, rsp_pass_last);
            if ($urandom_range(0, 39) == 0) receiver_gaps = !receiver_gaps;
            hold_left = receiver_gaps ? $urandom_range(0, 11) : 0;
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         rsp_stall <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   // Offer one request word after a random gap and hold it until accepted.
   // Valid stays high on return, so the caller either sends again in the same
   // step or drops it through settle().
   task automatic send_word(input logic mode, input logic [WORD_BITS-1:0] rd,
                            input logic restart);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_read_word <= rd;
      req_restart   <= restart;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_word(mode, rd, restart);
      items_sent++;
   endtask

   // Drop valid and wait for every outstanding result word.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write the pass length only with the core idle.
   task automatic write_length(input logic [LEN_BITS-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_length(value);
      csr_valid <= 1'b0;
   endtask

   // Read-back data for check mode: mostly the correct pattern, sometimes a
   // single flipped bit or garbage.
   function automatic logic [WORD_BITS-1:0] pick_read_word(input logic restart);
      logic [WORD_BITS-1:0] good;
      good = sb.peek_word(restart);
      case ($urandom_range(0, 9))
         0:       return WORD_BITS'($urandom);
         1:       return good ^ (16'd1 << $urandom_range(0, 15));
         default: return good;
      endcase
   endfunction

   function automatic logic [LEN_BITS-1:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return 32'd2;
         1:       return 32'd3;
         2:       return LEN_BITS'($urandom_range(0, 1));
         3, 4:    return LEN_BITS'($urandom_range(4, 200));
         5:       return LEN_BITS'($urandom_range(1026, 1100));
         6:       return 32'hFFFF_FFFF;
         7:       return LEN_RESET;
         8:       return LEN_BITS'($urandom);
         default: return 32'hFFFF_FFFE;
      endcase
   endfunction

   initial begin
      int          phase;
      int          words;
      int          style;
      logic        mode;
      logic        restart;
      logic [WORD_BITS-1:0] rd;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset length, generate words (read data ignored), check-mode
      // hit, miss, and the all-ones/all-zeros read extremes.
      send_word(1'b0, 16'h0000, 1'b0);
      send_word(1'b0, 16'hFFFF, 1'b0);
      send_word(1'b1, sb.peek_word(1'b0), 1'b0);
      send_word(1'b1, ~sb.peek_word(1'b0), 1'b0);
      send_word(1'b1, 16'hFFFF, 1'b0);
      send_word(1'b1, 16'h0000, 1'b0);
      // Short length: every word closes its pass.
      write_length(32'd0);
      send_word(1'b1, sb.peek_word(1'b0), 1'b0);
      send_word(1'b1, 16'h1234, 1'b0);
      write_length(32'd1);
      send_word(1'b0, 16'hFFFF, 1'b1);
      // Odd length: trailing byte dropped, still one word.
      write_length(32'd3);
      send_word(1'b1, sb.peek_word(1'b0), 1'b0);
      send_word(1'b1, 16'h8001, 1'b0);
      // Longest pass, then shrink below the words already covered: the next
      // word must close the pass.
      write_length(32'hFFFF_FFFF);
      send_word(1'b0, 16'h0000, 1'b1);
      send_word(1'b1, sb.peek_word(1'b0), 1'b0);
      send_word(1'b0, 16'h0000, 1'b0);
      send_word(1'b1, 16'hFFFF, 1'b0);
      write_length(32'd6);
      send_word(1'b1, sb.peek_word(1'b0), 1'b0);
      send_word(1'b0, 16'h0000, 1'b0);
      send_word(1'b1, 16'h5555, 1'b0);
      // Restart in the middle of a pass.
      write_length(32'd64);
      send_word(1'b0, 16'h0000, 1'b1);
      repeat (5) send_word(1'b1, sb.peek_word(1'b0), 1'b0);
      send_word(1'b1, sb.peek_word(1'b1), 1'b1);
      send_word(1'b1, 16'hAAAA, 1'b0);

      // Random phases. The first one is a long clean check pass that carries
      // the walking bit through all sixteen positions and wraps it.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 0) begin
            write_length(32'd1040);
            words = 540;
            style = 1;
         end else begin
            write_length(pick_length());
            words = $urandom_range(20, 90);
            style = $urandom_range(0, 2);
         end
         sender_gaps = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < words; i++) begin
            // Hold the result side off while requests keep coming, so the
            // core fills up and stalls its input.
            if (phase == 2 && i == 3) hold_request = LONG_HOLD;
            // Pause until every outstanding word has come back.
            if (phase == 4 && i == words / 2) settle();
            // Start the clean pass from its first word and never break it.
            if (i == 0)
               restart = (phase == 0) || ($urandom_range(0, 3) != 0);
            else
               restart = (phase != 0) && ($urandom_range(0, 29) == 0);
            case (style)
               0:       mode = 1'b0;
               1:       mode = 1'b1;
               default: mode = 1'($urandom_range(0, 1));
            endcase
            rd = mode ? pick_read_word(restart) : WORD_BITS'($urandom);
            send_word(mode, rd, restart);
         end
         phase++;
      end

      // Drain, then leave the core idle so that any stray word shows.
      settle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
